### rtl/core/nirpd_pkg.sv
// Shared types, constants and helper functions for the NEC IR pulse decoder.
`default_nettype none

package nirpd_pkg;

  // Field and register widths
  localparam int PERIOD_W  = 16;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int BIT_CNT_W = 6;
  localparam int NUM_CFG   = 8;

  // A full frame carries 32 data bits.
  localparam logic [BIT_CNT_W-1:0] FRAME_BITS = 6'd32;

  // Result kinds
  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_REPEAT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX   = 3'd7;

  // Reset values of the window bounds in timer ticks
  localparam logic [PERIOD_W-1:0] START_MIN_RST  = 16'd13400;
  localparam logic [PERIOD_W-1:0] START_MAX_RST  = 16'd13600;
  localparam logic [PERIOD_W-1:0] REPEAT_MIN_RST = 16'd11150;
  localparam logic [PERIOD_W-1:0] REPEAT_MAX_RST = 16'd11350;
  localparam logic [PERIOD_W-1:0] ONE_MIN_RST    = 16'd2150;
  localparam logic [PERIOD_W-1:0] ONE_MAX_RST    = 16'd2350;
  localparam logic [PERIOD_W-1:0] ZERO_MIN_RST   = 16'd1020;
  localparam logic [PERIOD_W-1:0] ZERO_MAX_RST   = 16'd1220;

  // Queue between classifier and frame assembler
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;
  localparam logic [Q_CNT_W-1:0] Q_FULL_CNT = 2'd2;

  // Period classes, in falling priority
  typedef enum logic [1:0] {
    CLS_START,
    CLS_REPEAT,
    CLS_ONE,
    CLS_ZERO
  } cls_t;

  // One classified period handed to the queue
  typedef struct packed {
    logic valid;
    cls_t cls;
  } item_t;

  // Strict window test: lo < p < hi.
  function automatic logic in_window(input logic [PERIOD_W-1:0] p,
                                     input logic [PERIOD_W-1:0] lo,
                                     input logic [PERIOD_W-1:0] hi);
    in_window = (p > lo) && (p < hi);
  endfunction

  // Bit reversal of one byte.
  function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = v[BYTE_W-1-i];
    end
    flip8 = r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/nec_ir_pulse_decoder.sv
// Top level of the NEC infrared pulse decoder.
`default_nettype none

// Decodes NEC remote frames from edge-to-edge periods given in timer ticks.
// Each accepted period is classified against the start, repeat, one and
// zero windows (strict bounds, in that priority) and placed in a two-entry
// queue; the frame assembler pops one entry per cycle while the result register
// is free or drains, shifts data bits into the four bytes and loads the result
// register on a checked 32nd bit or a repeat code. One period is accepted every
// cycle while the result register drains, and the queue absorbs a stall of the
// result channel until both entries are used.

module nec_ir_pulse_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [nirpd_pkg::PERIOD_W-1:0]    in_pulse_period,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_kind,
  output logic [nirpd_pkg::BYTE_W-1:0]           out_address,
  output logic [nirpd_pkg::BYTE_W-1:0]           out_address_check,
  output logic [nirpd_pkg::BYTE_W-1:0]           out_command,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [nirpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nirpd_pkg::PERIOD_W-1:0]    cfg_data
);

  nirpd_pkg::item_t push;
  nirpd_pkg::cls_t  q_cls;
  logic             q_not_full, q_valid, pop;

  // Front end
  nirpd_classify u_classify (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pulse_period (in_pulse_period),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_not_full      (q_not_full),
    .push            (push)
  );

  // Decoupling queue
  nirpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .not_full (q_not_full),
    .q_valid  (q_valid),
    .q_cls    (q_cls),
    .pop      (pop)
  );

  // Back end
  nirpd_frame u_frame (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cls             (q_cls),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_address       (out_address),
    .out_address_check (out_address_check),
    .out_command       (out_command)
  );

endmodule

`default_nettype wire

### rtl/core/nirpd_classify.sv
// Front end: window registers and classification of each accepted period.
`default_nettype none

module nirpd_classify (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [nirpd_pkg::PERIOD_W-1:0]    in_pulse_period,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [nirpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nirpd_pkg::PERIOD_W-1:0]    cfg_data,
  input  wire logic                              q_not_full,
  output nirpd_pkg::item_t                       push
);

  logic [nirpd_pkg::PERIOD_W-1:0] start_min_r, start_max_r, repeat_min_r, repeat_max_r;
  logic [nirpd_pkg::PERIOD_W-1:0] one_min_r, one_max_r, zero_min_r, zero_max_r;
  logic hit_start, hit_repeat, hit_one, hit_zero;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  // Window bound registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_min_r  <= nirpd_pkg::START_MIN_RST;
      start_max_r  <= nirpd_pkg::START_MAX_RST;
      repeat_min_r <= nirpd_pkg::REPEAT_MIN_RST;
      repeat_max_r <= nirpd_pkg::REPEAT_MAX_RST;
      one_min_r    <= nirpd_pkg::ONE_MIN_RST;
      one_max_r    <= nirpd_pkg::ONE_MAX_RST;
      zero_min_r   <= nirpd_pkg::ZERO_MIN_RST;
      zero_max_r   <= nirpd_pkg::ZERO_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        nirpd_pkg::REG_START_MIN:  start_min_r  <= cfg_data;
        nirpd_pkg::REG_START_MAX:  start_max_r  <= cfg_data;
        nirpd_pkg::REG_REPEAT_MIN: repeat_min_r <= cfg_data;
        nirpd_pkg::REG_REPEAT_MAX: repeat_max_r <= cfg_data;
        nirpd_pkg::REG_ONE_MIN:    one_min_r    <= cfg_data;
        nirpd_pkg::REG_ONE_MAX:    one_max_r    <= cfg_data;
        nirpd_pkg::REG_ZERO_MIN:   zero_min_r   <= cfg_data;
        nirpd_pkg::REG_ZERO_MAX:   zero_max_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input is taken whenever the queue has room.
  assign in_ready = q_not_full;

  // Window hits
  assign hit_start  = nirpd_pkg::in_window(in_pulse_period, start_min_r, start_max_r);
  assign hit_repeat = nirpd_pkg::in_window(in_pulse_period, repeat_min_r, repeat_max_r);
  assign hit_one    = nirpd_pkg::in_window(in_pulse_period, one_min_r, one_max_r);
  assign hit_zero   = nirpd_pkg::in_window(in_pulse_period, zero_min_r, zero_max_r);

  // Priority pick; a period in no window is dropped here.
  always_comb begin
    push.valid = in_valid && in_ready &&
                 (hit_start || hit_repeat || hit_one || hit_zero);
    if (hit_start) begin
      push.cls = nirpd_pkg::CLS_START;
    end else if (hit_repeat) begin
      push.cls = nirpd_pkg::CLS_REPEAT;
    end else if (hit_one) begin
      push.cls = nirpd_pkg::CLS_ONE;
    end else begin
      push.cls = nirpd_pkg::CLS_ZERO;
    end
  end

endmodule

`default_nettype wire

### rtl/core/nirpd_queue.sv
// Two-entry queue of classified periods between front end and frame assembler.
`default_nettype none

module nirpd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire nirpd_pkg::item_t   push,
  output logic                    not_full,
  output logic                    q_valid,
  output nirpd_pkg::cls_t         q_cls,
  input  wire logic               pop
);

  nirpd_pkg::cls_t                 mem_r [nirpd_pkg::Q_DEPTH];
  logic [nirpd_pkg::Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [nirpd_pkg::Q_CNT_W-1:0]   count_r, count_nxt;
  logic                            do_pop;

  assign not_full = (count_r != nirpd_pkg::Q_FULL_CNT);
  assign q_valid  = (count_r != '0);
  assign q_cls    = mem_r[rd_ptr_r];
  assign do_pop   = pop && q_valid;

  // Occupancy update
  always_comb begin
    count_nxt = count_r;
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.cls;
    end
  end

endmodule

`default_nettype wire

### rtl/core/nirpd_frame.sv
// Back end: bit counter, byte shift registers, frame check and result register.
`default_nettype none

module nirpd_frame (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  input  wire nirpd_pkg::cls_t                 q_cls,
  output logic                                 pop,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_kind,
  output logic [nirpd_pkg::BYTE_W-1:0]         out_address,
  output logic [nirpd_pkg::BYTE_W-1:0]         out_address_check,
  output logic [nirpd_pkg::BYTE_W-1:0]         out_command
);

  logic [nirpd_pkg::BIT_CNT_W-1:0] bits_r, bits_nxt;
  logic [nirpd_pkg::BYTE_W-1:0]    addr_r, addr_nxt, addr_inv_r, addr_inv_nxt;
  logic [nirpd_pkg::BYTE_W-1:0]    cmd_r, cmd_nxt, cmd_inv_r, cmd_inv_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            kind_r;
  logic [nirpd_pkg::BYTE_W-1:0]    address_r, address_check_r, command_r;
  logic                            result, result_kind, bit_val;

  // Take the next queue entry whenever the result register is free or drains.
  assign pop     = q_valid && (!out_valid_r || out_ready);
  assign bit_val = (q_cls == nirpd_pkg::CLS_ONE);

  // State update for the popped period
  always_comb begin
    bits_nxt     = bits_r;
    addr_nxt     = addr_r;
    addr_inv_nxt = addr_inv_r;
    cmd_nxt      = cmd_r;
    cmd_inv_nxt  = cmd_inv_r;
    result       = 1'b0;
    result_kind  = nirpd_pkg::KIND_FRAME;
    if (pop) begin
      case (q_cls)
        nirpd_pkg::CLS_START: begin
          bits_nxt     = '0;
          addr_nxt     = '0;
          addr_inv_nxt = '0;
          cmd_nxt      = '0;
          cmd_inv_nxt  = '0;
        end
        nirpd_pkg::CLS_REPEAT: begin
          result      = 1'b1;
          result_kind = nirpd_pkg::KIND_REPEAT;
        end
        nirpd_pkg::CLS_ONE, nirpd_pkg::CLS_ZERO: begin
          if (bits_r < nirpd_pkg::FRAME_BITS) begin
            // Bits 4:3 of the count pick the byte being filled.
            case (bits_r[4:3])
              2'd0:    addr_nxt     = {addr_r[nirpd_pkg::BYTE_W-2:0], bit_val};
              2'd1:    addr_inv_nxt = {addr_inv_r[nirpd_pkg::BYTE_W-2:0], bit_val};
              2'd2:    cmd_nxt      = {cmd_r[nirpd_pkg::BYTE_W-2:0], bit_val};
              default: cmd_inv_nxt  = {cmd_inv_r[nirpd_pkg::BYTE_W-2:0], bit_val};
            endcase
            bits_nxt = bits_r + 1'b1;
            if ((bits_nxt == nirpd_pkg::FRAME_BITS) && (cmd_nxt == ~cmd_inv_nxt)) begin
              result = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register valid flag
  always_comb begin
    if (result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and shift state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r      <= '0;
      addr_r      <= '0;
      addr_inv_r  <= '0;
      cmd_r       <= '0;
      cmd_inv_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bits_r      <= bits_nxt;
      addr_r      <= addr_nxt;
      addr_inv_r  <= addr_inv_nxt;
      cmd_r       <= cmd_nxt;
      cmd_inv_r   <= cmd_inv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, bytes turned so the first received bit lands in bit 0
  always_ff @(posedge clk) begin
    if (result) begin
      kind_r          <= result_kind;
      address_r       <= nirpd_pkg::flip8(addr_nxt);
      address_check_r <= nirpd_pkg::flip8(addr_inv_nxt);
      command_r       <= nirpd_pkg::flip8(cmd_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_address       = address_r;
  assign out_address_check = address_check_r;
  assign out_command       = command_r;

endmodule

`default_nettype wire

### rtl/core/nirpd_checker.sv
// Port-level assertions for the NEC IR pulse decoder and their bind.
`default_nettype none

module nirpd_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              out_kind,
  input wire logic [nirpd_pkg::BYTE_W-1:0]      out_address,
  input wire logic [nirpd_pkg::BYTE_W-1:0]      out_address_check,
  input wire logic [nirpd_pkg::BYTE_W-1:0]      out_command,
  input wire logic                              cfg_ready
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_address) && $stable(out_address_check) && $stable(out_command))
    else $error("result changed while stalled");

  // No result is pending right after reset.
  a_out_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // The input only backs up behind a pending result.
  a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // Register writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration write refused");

  // The input side is ready in the first cycle after reset.
  a_in_ready_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind nec_ir_pulse_decoder nirpd_checker u_nirpd_checker (.*);

`default_nettype wire

### tb/nec_ir_pulse_decoder_test.sv
// Self-checking testbench for the NEC infrared pulse decoder.
`timescale 1ns / 100ps

module nec_ir_pulse_decoder_test;

  // One decoded result as it leaves the block.
  typedef struct packed {
    logic                        kind;
    logic [nirpd_pkg::BYTE_W-1:0] address;
    logic [nirpd_pkg::BYTE_W-1:0] address_check;
    logic [nirpd_pkg::BYTE_W-1:0] command;
  } ir_result_t;

  // One row of the directed table: a period and, where obvious, its result.
  typedef struct packed {
    logic [nirpd_pkg::PERIOD_W-1:0] period;
    logic                           typed;
    ir_result_t                     want;
  } period_row_t;

  localparam int NUM_ROWS       = 21;
  localparam int NUM_SETS       = 5;
  localparam int PHASE_GOAL     = 95;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RX_HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT    = 200000;

  localparam ir_result_t NO_RESULT = '0;

  // Directed periods under the reset windows: field extremes, every window edge
  // (exclusive, so ignored), one tick inside each edge, repeats before any frame
  // and in the middle of a frame.
  localparam period_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{16'd0,     1'b0, NO_RESULT},
    '{16'd65535, 1'b0, NO_RESULT},
    '{16'd11200, 1'b1, '{nirpd_pkg::KIND_REPEAT, 8'h00, 8'h00, 8'h00}},
    '{16'd13400, 1'b0, NO_RESULT},
    '{16'd13600, 1'b0, NO_RESULT},
    '{16'd13500, 1'b0, NO_RESULT},
    '{16'd2150,  1'b0, NO_RESULT},
    '{16'd2151,  1'b0, NO_RESULT},
    '{16'd1020,  1'b0, NO_RESULT},
    '{16'd1021,  1'b0, NO_RESULT},
    '{16'd2350,  1'b0, NO_RESULT},
    '{16'd2349,  1'b0, NO_RESULT},
    '{16'd1220,  1'b0, NO_RESULT},
    '{16'd1219,  1'b0, NO_RESULT},
    '{16'd11150, 1'b0, NO_RESULT},
    '{16'd11350, 1'b0, NO_RESULT},
    '{16'd11151, 1'b1, '{nirpd_pkg::KIND_REPEAT, 8'h50, 8'h00, 8'h00}},
    '{16'd11349, 1'b1, '{nirpd_pkg::KIND_REPEAT, 8'h50, 8'h00, 8'h00}},
    '{16'd13599, 1'b0, NO_RESULT},
    '{16'd11200, 1'b1, '{nirpd_pkg::KIND_REPEAT, 8'h00, 8'h00, 8'h00}},
    '{16'd13401, 1'b0, NO_RESULT}
  };

  // Window settings in register order: start, repeat, one and zero bounds.
  // Narrow, overlapping, wide repeat with an empty start window, single-tick
  // bit windows with an inverted repeat window, and the reset values.
  localparam logic [nirpd_pkg::PERIOD_W-1:0]
    WINDOW_SETS [NUM_SETS][nirpd_pkg::NUM_CFG] = '{
    '{16'd5000,  16'd5200,  16'd4000, 16'd4100,  16'd300, 16'd400,
      16'd100,   16'd200},
    '{16'd2000,  16'd4000,  16'd1000, 16'd3000,  16'd500, 16'd2500,
      16'd0,     16'd1500},
    '{16'd65534, 16'd65535, 16'd0,    16'd65535, 16'd0,   16'd65535,
      16'd0,     16'd65535},
    '{16'd30000, 16'd40000, 16'd9000, 16'd8000,  16'd0,   16'd2,
      16'd65533, 16'd65535},
    '{nirpd_pkg::START_MIN_RST,  nirpd_pkg::START_MAX_RST,
      nirpd_pkg::REPEAT_MIN_RST, nirpd_pkg::REPEAT_MAX_RST,
      nirpd_pkg::ONE_MIN_RST,    nirpd_pkg::ONE_MAX_RST,
      nirpd_pkg::ZERO_MIN_RST,   nirpd_pkg::ZERO_MAX_RST}
  };

  // Clock, reset and block ports.
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [nirpd_pkg::PERIOD_W-1:0]  in_pulse_period = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_kind;
  logic [nirpd_pkg::BYTE_W-1:0]    out_address;
  logic [nirpd_pkg::BYTE_W-1:0]    out_address_check;
  logic [nirpd_pkg::BYTE_W-1:0]    out_command;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [nirpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [nirpd_pkg::PERIOD_W-1:0]  cfg_data = '0;

  // Decoder state as predicted by the testbench.
  logic [nirpd_pkg::PERIOD_W-1:0]  bound [nirpd_pkg::NUM_CFG];
  logic [nirpd_pkg::BIT_CNT_W-1:0] bits_taken = '0;
  logic [nirpd_pkg::BYTE_W-1:0]    addr_byte = '0;
  logic [nirpd_pkg::BYTE_W-1:0]    addr_inv_byte = '0;
  logic [nirpd_pkg::BYTE_W-1:0]    cmd_byte = '0;
  logic [nirpd_pkg::BYTE_W-1:0]    cmd_inv_byte = '0;

  ir_result_t                     predicted_codes [$];
  logic [nirpd_pkg::PERIOD_W-1:0] stim_periods [$];

  int error_count = 0;
  int cycle_count = 0;
  int periods_sent = 0;
  int periods_in_window = 0;
  int frames_seen = 0;
  int repeats_seen = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;

  nec_ir_pulse_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pulse_period   (in_pulse_period),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_address       (out_address),
    .out_address_check (out_address_check),
    .out_command       (out_command),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending.",
               cycle_count, predicted_codes.size());
      $display("nec_ir_pulse_decoder_test: done, errors");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Advance the predicted decoder by one period. Windows are tested in
  // priority order with strict bounds. Bytes shift right with the new bit at
  // the top, which leaves the first received bit at the bottom of a full byte.
  task automatic decode_period(input logic [nirpd_pkg::PERIOD_W-1:0] p, output bit hit,
                               output bit got, output ir_result_t res);
    logic data_bit;
    hit = 1'b1;
    got = 1'b0;
    res = NO_RESULT;
    data_bit = 1'b0;
    if (p > bound[nirpd_pkg::REG_START_MIN] && p < bound[nirpd_pkg::REG_START_MAX]) begin
      bits_taken = '0;
      addr_byte = '0;
      addr_inv_byte = '0;
      cmd_byte = '0;
      cmd_inv_byte = '0;
    end else if (p > bound[nirpd_pkg::REG_REPEAT_MIN] &&
                 p < bound[nirpd_pkg::REG_REPEAT_MAX]) begin
      got = 1'b1;
      res = '{nirpd_pkg::KIND_REPEAT, addr_byte, addr_inv_byte, cmd_byte};
    end else begin
      if (p > bound[nirpd_pkg::REG_ONE_MIN] && p < bound[nirpd_pkg::REG_ONE_MAX]) begin
        data_bit = 1'b1;
      end else if (p > bound[nirpd_pkg::REG_ZERO_MIN] &&
                   p < bound[nirpd_pkg::REG_ZERO_MAX]) begin
        data_bit = 1'b0;
      end else begin
        hit = 1'b0;
      end
      // Bits past a full frame are dropped until the next start.
      if (hit && bits_taken < nirpd_pkg::FRAME_BITS) begin
        case (bits_taken[4:3])
          2'd0: addr_byte = {data_bit, addr_byte[nirpd_pkg::BYTE_W-1:1]};
          2'd1: addr_inv_byte = {data_bit, addr_inv_byte[nirpd_pkg::BYTE_W-1:1]};
          2'd2: cmd_byte = {data_bit, cmd_byte[nirpd_pkg::BYTE_W-1:1]};
          default: cmd_inv_byte = {data_bit, cmd_inv_byte[nirpd_pkg::BYTE_W-1:1]};
        endcase
        bits_taken = bits_taken + 1'b1;
        if (bits_taken == nirpd_pkg::FRAME_BITS && cmd_byte == ~cmd_inv_byte) begin
          got = 1'b1;
          res = '{nirpd_pkg::KIND_FRAME, addr_byte, addr_inv_byte, cmd_byte};
        end
      end
    end
  endtask

  // Offer one period, idling first at the current rate, and record what the
  // decoder should give for it once the transaction completes.
  task automatic send_period(input logic [nirpd_pkg::PERIOD_W-1:0] p, input logic typed,
                             input ir_result_t want);
    bit hit;
    bit got;
    ir_result_t res;
    if ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_pulse_period <= p;
    do @(posedge clk); while (!in_ready);
    decode_period(p, hit, got, res);
    if (typed) begin
      predicted_codes.push_back(want);
    end else if (got) begin
      predicted_codes.push_back(res);
    end
    periods_sent++;
    if (hit) periods_in_window++;
  endtask

  // Compare one result transaction against the oldest prediction.
  task automatic check_result();
    ir_result_t seen;
    ir_result_t want;
    seen = '{out_kind, out_address, out_address_check, out_command};
    if (seen.kind == nirpd_pkg::KIND_REPEAT) repeats_seen++;
    else frames_seen++;
    if (predicted_codes.size() == 0) begin
      flag_error($sformatf("unexpected result kind %0d addr %02h/%02h cmd %02h",
                           seen.kind, seen.address, seen.address_check, seen.command));
    end else begin
      want = predicted_codes.pop_front();
      if (seen.kind !== want.kind)
        flag_error($sformatf("kind %0d, expected %0d", seen.kind, want.kind));
      if (seen.address !== want.address)
        flag_error($sformatf("address %02h, expected %02h", seen.address, want.address));
      if (seen.address_check !== want.address_check)
        flag_error($sformatf("address_check %02h, expected %02h",
                             seen.address_check, want.address_check));
      if (seen.command !== want.command)
        flag_error($sformatf("command %02h, expected %02h", seen.command, want.command));
    end
  endtask

  // Result side: random backpressure plus, on request, one long hold-off.
  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_result();
      if (holds_served != hold_requests) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end
      out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // A random period strictly inside a window, or any value if it is too narrow.
  function automatic logic [nirpd_pkg::PERIOD_W-1:0] pick_between(
      input logic [nirpd_pkg::PERIOD_W-1:0] lo,
      input logic [nirpd_pkg::PERIOD_W-1:0] hi);
    int lo_i;
    int hi_i;
    lo_i = lo;
    hi_i = hi;
    if (hi_i - lo_i >= 2)
      return nirpd_pkg::PERIOD_W'($urandom_range(hi_i - 1, lo_i + 1));
    return nirpd_pkg::PERIOD_W'($urandom);
  endfunction

  // A start period followed by data bits; mostly a clean frame, sometimes
  // a bad command check, a truncated frame or extra bits, then a few repeats.
  task automatic queue_frame();
    logic [nirpd_pkg::BYTE_W-1:0] frame_bytes [4];
    int nbits;
    int roll;
    frame_bytes[0] = nirpd_pkg::BYTE_W'($urandom);
    frame_bytes[1] = $urandom_range(1, 0) ? ~frame_bytes[0] : nirpd_pkg::BYTE_W'($urandom);
    frame_bytes[2] = nirpd_pkg::BYTE_W'($urandom);
    frame_bytes[3] = ($urandom_range(99, 0) < 85) ? ~frame_bytes[2] :
                                                   nirpd_pkg::BYTE_W'($urandom);
    nbits = 32;
    roll = $urandom_range(99, 0);
    if (roll < 10) nbits = $urandom_range(31, 1);
    else if (roll < 20) nbits = 32 + $urandom_range(4, 1);
    stim_periods.push_back(pick_between(bound[nirpd_pkg::REG_START_MIN],
                                        bound[nirpd_pkg::REG_START_MAX]));
    for (int i = 0; i < nbits; i++) begin
      if (frame_bytes[(i / 8) % 4][i % 8])
        stim_periods.push_back(pick_between(bound[nirpd_pkg::REG_ONE_MIN],
                                            bound[nirpd_pkg::REG_ONE_MAX]));
      else
        stim_periods.push_back(pick_between(bound[nirpd_pkg::REG_ZERO_MIN],
                                            bound[nirpd_pkg::REG_ZERO_MAX]));
    end
    repeat ($urandom_range(2, 0))
      stim_periods.push_back(pick_between(bound[nirpd_pkg::REG_REPEAT_MIN],
                                          bound[nirpd_pkg::REG_REPEAT_MAX]));
  endtask

  // Wait until every predicted result has arrived and the pipeline is empty.
  task automatic drain_block();
    while (predicted_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all eight window bounds back to back, keeping valid high.
  task automatic load_windows(input int set_idx);
    for (int i = 0; i < nirpd_pkg::NUM_CFG; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= nirpd_pkg::CFG_IDX_W'(i);
      cfg_data <= WINDOW_SETS[set_idx][i];
      do @(posedge clk); while (!cfg_ready);
      bound[i] = WINDOW_SETS[set_idx][i];
    end
    cfg_valid <= 1'b0;
  endtask

  // One random phase under one window setting.
  task automatic run_phase(input int set_idx, input bit squeeze);
    int first_count;
    int roll;
    drain_block();
    load_windows(set_idx);
    if (squeeze) hold_requests++;
    first_count = periods_in_window;
    while (periods_in_window - first_count < PHASE_GOAL) begin
      roll = $urandom_range(99, 0);
      if (roll < 70) begin
        queue_frame();
      end else if (roll < 85) begin
        repeat ($urandom_range(3, 1))
          stim_periods.push_back(pick_between(bound[nirpd_pkg::REG_REPEAT_MIN],
                                              bound[nirpd_pkg::REG_REPEAT_MAX]));
      end else begin
        // Noise: arbitrary periods and values right on or next to a bound.
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(1, 0))
            stim_periods.push_back(nirpd_pkg::PERIOD_W'($urandom));
          else
            stim_periods.push_back(nirpd_pkg::PERIOD_W'(
              bound[$urandom_range(nirpd_pkg::NUM_CFG - 1, 0)] + $urandom_range(2, 0) - 1));
        end
      end
      while (stim_periods.size() != 0)
        send_period(stim_periods.pop_front(), 1'b0, NO_RESULT);
    end
    in_valid <= 1'b0;
  endtask

  // Main sequence.
  initial begin
    bound[nirpd_pkg::REG_START_MIN]  = nirpd_pkg::START_MIN_RST;
    bound[nirpd_pkg::REG_START_MAX]  = nirpd_pkg::START_MAX_RST;
    bound[nirpd_pkg::REG_REPEAT_MIN] = nirpd_pkg::REPEAT_MIN_RST;
    bound[nirpd_pkg::REG_REPEAT_MAX] = nirpd_pkg::REPEAT_MAX_RST;
    bound[nirpd_pkg::REG_ONE_MIN]    = nirpd_pkg::ONE_MIN_RST;
    bound[nirpd_pkg::REG_ONE_MAX]    = nirpd_pkg::ONE_MAX_RST;
    bound[nirpd_pkg::REG_ZERO_MIN]   = nirpd_pkg::ZERO_MIN_RST;
    bound[nirpd_pkg::REG_ZERO_MAX]   = nirpd_pkg::ZERO_MAX_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender mostly busy, receiver mostly stalled.
    tx_idle_pct = 19;
    rx_idle_pct = 79;
    for (int i = 0; i < NUM_ROWS; i++)
      send_period(DIRECTED_ROWS[i].period, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    in_valid <= 1'b0;
    run_phase(0, 1'b0);
    run_phase(1, 1'b0);

    // Roles swapped; the wide repeat window makes every period from 1 to 65534 a result,
    // so the long receiver hold-off backs the block up to its input.
    tx_idle_pct = 79;
    rx_idle_pct = 19;
    run_phase(2, 1'b1);
    run_phase(3, 1'b0);

    // No idling on either side, back on the reset windows.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(4, 1'b0);
    drain_block();

    $display("Sent %0d periods (%0d inside a window); checked %0d frames and %0d repeats.",
             periods_sent, periods_in_window, frames_seen, repeats_seen);
    $display("Window sets: reset, narrow, overlapping, wide repeat, empty and one-tick.");
    if (error_count == 0) begin
      $display("nec_ir_pulse_decoder_test: done, clean");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("nec_ir_pulse_decoder_test: done, errors");
    end
    $finish;
  end

endmodule
